// ----- hw/rtl/scc_pkg.sv -----
package scc_pkg;
	localparam int unsigned MaxVertices = 64;
	localparam int unsigned MaxEdges = 256;
	localparam int unsigned VertW = 6;
	localparam int unsigned CountW = 7;
endpackage

// ----- hw/rtl/strongly_connected_components_unit.sv -----
// channel | signals                                         | dir
// input   | valid ready edge_from edge_to edge_present run_after | in
// output  | out_valid out_ready vertex_index component_index ... | out
// config  | cfg_we cfg_wdata                                 | in
// loading: one word per cycle when it carries no run request.
// each edge scan step is a memory read (ST_RD) followed by a compare (ST_SCAN) on the single read port;
// each result passes a fetch state and a present state; a stalled output holds the word.
// reset initialises all control state (vertex count to 64); edge memory contents are not cleared.
module strongly_connected_components_unit #(
	parameter int unsigned MAX_VERTICES = scc_pkg::MaxVertices,
	parameter int unsigned MAX_EDGES = scc_pkg::MaxEdges
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       ready,
	input  logic [5:0] edge_from,
	input  logic [5:0] edge_to,
	input  logic       edge_present,
	input  logic       run_after,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] vertex_index,
	output logic [5:0] component_index,
	output logic [6:0] component_total,
	output logic       edges_dropped,
	output logic       last_result,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata
);
	import scc_pkg::*;

	localparam int unsigned EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
	localparam int unsigned VA = $clog2(MAX_VERTICES);
	localparam int unsigned VC = $clog2(MAX_VERTICES + 1);

	typedef enum logic [3:0] {
		ST_LOAD, ST_ROOT, ST_RROOT, ST_RCHK, ST_TOP, ST_TLD, ST_RD, ST_SCAN, ST_POP,
		ST_FETCH, ST_EMIT, ST_CLR
	} state_t;

	function automatic logic [VA-1:0] top_f(input logic [VC-1:0] i);
		logic [VC-1:0] j;
		j = i - 1'b1;
		return j[VA-1:0];
	endfunction

	state_t state_q;
	logic [6:0] vcount_q;
	logic [ECW-1:0] etotal_q;
	logic drop_q;
	logic rev_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [5:0] finish_q [MAX_VERTICES];
	logic [5:0] fin_rd_q;
	logic [VC-1:0] ftotal_q;
	logic [5:0] svert_q [MAX_VERTICES];
	logic [ECW-1:0] scur_q [MAX_VERTICES];
	logic [5:0] sv_rd_q;
	logic [ECW-1:0] sc_rd_q;
	logic [VC-1:0] depth_q;
	logic [5:0] comp_q [MAX_VERTICES];
	logic [5:0] comp_rd_q;
	logic [6:0] ccount_q;
	logic [VC-1:0] vidx_q;
	logic [ECW-1:0] cur_q;
	logic [5:0] topv_q;

	logic [VC-1:0] n;
	assign n = (vcount_q > 7'(MAX_VERTICES)) ? VC'(MAX_VERTICES) : VC'(vcount_q);

	logic acc, edge_ok, mem_we;
	logic [11:0] rd;
	logic [EA-1:0] raddr;
	assign ready = (state_q == ST_LOAD);
	assign acc = valid && ready;
	assign edge_ok = ({1'b0, edge_from} < 7'(n)) && ({1'b0, edge_to} < 7'(n))
		&& (etotal_q < ECW'(MAX_EDGES));
	assign mem_we = acc && edge_present && edge_ok;
	assign raddr = cur_q[EA-1:0];

	scc_edge_mem #(.AW(EA), .DW(12)) u_mem (
		.clk(clk), .we(mem_we), .waddr(etotal_q[EA-1:0]),
		.wdata({edge_from, edge_to}), .raddr(raddr), .rdata(rd)
	);

	logic [5:0] ea, eb, here, nxt;
	logic hit;
	assign ea = rd[11:6];
	assign eb = rd[5:0];
	assign here = rev_q ? eb : ea;
	assign nxt = rev_q ? ea : eb;
	assign hit = (here == topv_q) && (7'(ea) < 7'(n)) && (7'(eb) < 7'(n))
		&& !visited_q[nxt[VA-1:0]] && (depth_q < VC'(MAX_VERTICES));

	logic [VC-1:0] top;
	assign top = depth_q - 1'b1;

	logic root_push, rev_push, edge_push;
	assign root_push = (state_q == ST_ROOT) && (vidx_q < n) && !visited_q[vidx_q[VA-1:0]];
	assign rev_push = (state_q == ST_RCHK) && !visited_q[fin_rd_q[VA-1:0]];
	assign edge_push = (state_q == ST_SCAN) && hit;

	logic fin_we;
	logic [VA-1:0] fin_ra;
	assign fin_we = (state_q == ST_POP) && !rev_q && (ftotal_q < VC'(MAX_VERTICES));
	assign fin_ra = top_f(vidx_q);

	logic sv_we;
	logic [VA-1:0] sv_wa;
	logic [5:0] sv_wd;
	assign sv_we = root_push || rev_push || edge_push;
	assign sv_wa = edge_push ? depth_q[VA-1:0] : '0;
	assign sv_wd = edge_push ? nxt : (rev_push ? fin_rd_q : VertW'(vidx_q));

	logic comp_we;
	logic [VA-1:0] comp_wa;
	assign comp_we = rev_push || (edge_push && rev_q);
	assign comp_wa = edge_push ? nxt[VA-1:0] : fin_rd_q[VA-1:0];

	// finish list, walk stack and component labels, all with registered reads
	always_ff @(posedge clk) begin
		if (fin_we) finish_q[ftotal_q[VA-1:0]] <= topv_q;
		if (sv_we) svert_q[sv_wa] <= sv_wd;
		// parent resumes after the edge that pushed the child
		if (edge_push) scur_q[top[VA-1:0]] <= cur_q + 1'b1;
		if (comp_we) comp_q[comp_wa] <= ccount_q[5:0];
		fin_rd_q <= finish_q[fin_ra];
		sv_rd_q <= svert_q[top[VA-1:0]];
		sc_rd_q <= scur_q[top[VA-1:0]];
		comp_rd_q <= comp_q[vidx_q[VA-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			vcount_q <= 7'd64;
			etotal_q <= '0;
			drop_q <= 1'b0;
			rev_q <= 1'b0;
			visited_q <= '0;
			ftotal_q <= '0;
			depth_q <= '0;
			ccount_q <= '0;
			vidx_q <= '0;
			cur_q <= '0;
			topv_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (edge_present) begin
							if (edge_ok) etotal_q <= etotal_q + 1'b1;
							else drop_q <= 1'b1;
						end
						if (run_after) begin
							visited_q <= '0;
							ftotal_q <= '0;
							rev_q <= 1'b0;
							vidx_q <= '0;
							state_q <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					// forward roots ascend over vertices
					if (vidx_q >= n) begin
						visited_q <= '0;
						ccount_q <= '0;
						rev_q <= 1'b1;
						vidx_q <= ftotal_q;
						state_q <= ST_RROOT;
					end else if (root_push) begin
						visited_q[vidx_q[VA-1:0]] <= 1'b1;
						topv_q <= VertW'(vidx_q);
						cur_q <= '0;
						depth_q <= VC'(1);
						state_q <= ST_RD;
						vidx_q <= vidx_q + 1'b1;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				ST_RROOT: begin
					// reverse roots walk finish list backward
					if (vidx_q == '0) begin
						state_q <= (n == '0) ? ST_CLR : ST_FETCH;
					end else begin
						vidx_q <= vidx_q - 1'b1;
						state_q <= ST_RCHK;
					end
				end
				ST_RCHK: begin
					if (rev_push) begin
						visited_q[fin_rd_q[VA-1:0]] <= 1'b1;
						topv_q <= fin_rd_q;
						cur_q <= '0;
						depth_q <= VC'(1);
						state_q <= ST_RD;
					end else begin
						state_q <= ST_RROOT;
					end
				end
				ST_TOP: begin
					if (depth_q == '0) begin
						if (rev_q) begin
							ccount_q <= ccount_q + 1'b1;
							state_q <= ST_RROOT;
						end else begin
							state_q <= ST_ROOT;
						end
					end else begin
						state_q <= ST_TLD;
					end
				end
				ST_TLD: begin
					topv_q <= sv_rd_q;
					cur_q <= sc_rd_q;
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= (cur_q < etotal_q) ? ST_SCAN : ST_POP;
				end
				ST_SCAN: begin
					if (hit) begin
						visited_q[nxt[VA-1:0]] <= 1'b1;
						topv_q <= nxt;
						cur_q <= '0;
						depth_q <= depth_q + 1'b1;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
					state_q <= ST_RD;
				end
				ST_POP: begin
					if (fin_we) begin
						ftotal_q <= ftotal_q + 1'b1;
					end
					depth_q <= depth_q - 1'b1;
					state_q <= ST_TOP;
				end
				ST_FETCH: begin
					out_valid <= 1'b1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (vidx_q + 1'b1 == n) begin
							state_q <= ST_CLR;
						end else begin
							vidx_q <= vidx_q + 1'b1;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_CLR: begin
					etotal_q <= '0;
					drop_q <= 1'b0;
					state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign vertex_index = VertW'(vidx_q);
	assign component_index = comp_rd_q;
	assign component_total = ccount_q;
	assign edges_dropped = drop_q;
	assign last_result = (vidx_q + 1'b1 == n);

`ifndef SYNTHESIS
	a_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> !out_valid) else $error("ready while emitting");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= VC'(MAX_VERTICES)) else $error("stack overflow");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |=> etotal_q == '0) else $error("store not cleared");
`endif
endmodule

// ----- hw/rtl/scc_edge_mem.sv -----
module scc_edge_mem #(
	parameter int unsigned AW = 8,
	parameter int unsigned DW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- tb/testbench.sv -----
module testbench;
	import scc_pkg::*;

	localparam int unsigned CycleLimit = 2000000;
	// covers the clear step and a run with no vertices, which gives no words
	localparam int unsigned RunCycles = 200;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [5:0] vertex;
		logic [5:0] component;
		logic [6:0] total;
		logic       dropped;
		logic       last;
	} vertex_word_t;

	class scc_scoreboard;
		bit [5:0] arc_src[MaxEdges];
		bit [5:0] arc_dst[MaxEdges];
		int unsigned arc_cnt;
		bit drop_flag;
		int unsigned vcount;
		bit seen[MaxVertices];
		int unsigned fin[MaxVertices];
		int unsigned fin_cnt;
		int unsigned vstk[MaxVertices];
		int unsigned cstk[MaxVertices];
		int unsigned depth;
		int unsigned comp_of[MaxVertices];
		vertex_word_t pending[$];
		int errors;

		function new();
			vcount = MaxVertices;
			arc_cnt = 0;
			drop_flag = 0;
			errors = 0;
		endfunction

		function int unsigned live();
			return (vcount > MaxVertices) ? MaxVertices : vcount;
		endfunction

		function void search(int unsigned root, int unsigned n, bit rev, int unsigned comp);
			int unsigned top, v, c, a, b, here, nxt;
			bit pushed;
			seen[root] = 1;
			if (rev) comp_of[root] = comp;
			vstk[0] = root;
			cstk[0] = 0;
			depth = 1;
			while (depth > 0) begin
				top = depth - 1;
				v = vstk[top];
				c = cstk[top];
				pushed = 0;
				while (c < arc_cnt) begin
					a = 32'(arc_src[c]);
					b = 32'(arc_dst[c]);
					here = rev ? b : a;
					nxt = rev ? a : b;
					c++;
					if (here == v && nxt < n && a < n && b < n && !seen[nxt]
							&& depth < MaxVertices) begin
						cstk[top] = c;
						seen[nxt] = 1;
						if (rev) comp_of[nxt] = comp;
						vstk[depth] = nxt;
						cstk[depth] = 0;
						depth++;
						pushed = 1;
						break;
					end
				end
				if (!pushed) begin
					if (!rev && fin_cnt < MaxVertices) begin
						fin[fin_cnt] = v;
						fin_cnt++;
					end
					depth--;
				end
			end
		endfunction

		function void note_word(bit [5:0] f, bit [5:0] t, bit present, bit run);
			int unsigned n, comps, s;
			vertex_word_t w;
			n = live();
			if (present) begin
				if (f < n && t < n && arc_cnt < MaxEdges) begin
					arc_src[arc_cnt] = f;
					arc_dst[arc_cnt] = t;
					arc_cnt++;
				end else begin
					drop_flag = 1;
				end
			end
			if (!run) return;
			foreach (seen[i]) seen[i] = 0;
			fin_cnt = 0;
			for (int unsigned v = 0; v < n; v++)
				if (!seen[v]) search(v, n, 0, 0);
			foreach (seen[i]) seen[i] = 0;
			comps = 0;
			for (int unsigned i = fin_cnt; i > 0; i--) begin
				s = fin[i - 1];
				if (s < n && !seen[s]) begin
					search(s, n, 1, comps);
					comps++;
				end
			end
			for (int unsigned v = 0; v < n; v++) begin
				w.vertex = v[5:0];
				w.component = comp_of[v][5:0];
				w.total = comps[6:0];
				w.dropped = drop_flag;
				w.last = (v + 1 == n);
				pending = {pending, w};
			end
			arc_cnt = 0;
			drop_flag = 0;
		endfunction

		function void check_word(vertex_word_t got);
			vertex_word_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic valid = 0;
	logic ready;
	logic [5:0] edge_from = 0;
	logic [5:0] edge_to = 0;
	logic edge_present = 0;
	logic run_after = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [5:0] vertex_index;
	logic [5:0] component_index;
	logic [6:0] component_total;
	logic edges_dropped;
	logic last_result;
	logic cfg_we = 0;
	logic [6:0] cfg_wdata = 0;

	scc_scoreboard sb = new();
	idle_mode_t mode = IDLE_NONE;
	bit hold_req = 0;
	int unsigned hold_left = 0;
	int unsigned cycles = 0;

	strongly_connected_components_unit uut (
		.clk(clk), .arst_n(arst_n),
		.valid(valid), .ready(ready),
		.edge_from(edge_from), .edge_to(edge_to),
		.edge_present(edge_present), .run_after(run_after),
		.out_valid(out_valid), .out_ready(out_ready),
		.vertex_index(vertex_index), .component_index(component_index),
		.component_total(component_total), .edges_dropped(edges_dropped),
		.last_result(last_result),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (out_valid && out_ready)
			sb.check_word({vertex_index, component_index, component_total,
				edges_dropped, last_result});
	end

	// receiver side, including the long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 2500;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 0;
		end else if (mode == IDLE_RECV) begin
			out_ready <= ($urandom_range(99) >= 73);
		end else if (mode == IDLE_BOTH) begin
			out_ready <= ($urandom_range(99) >= 12);
		end else begin
			out_ready <= 1;
		end
	end

	task automatic send_word(bit [5:0] f, bit [5:0] t, bit present, bit run);
		int unsigned pct;
		pct = (mode == IDLE_SEND) ? 73 : (mode == IDLE_BOTH) ? 12 : 0;
		while ($urandom_range(99) < pct) begin
			valid <= 0;
			@(negedge clk);
		end
		valid <= 1;
		edge_from <= f;
		edge_to <= t;
		edge_present <= present;
		run_after <= run;
		do @(posedge clk); while (!ready);
		sb.note_word(f, t, present, run);
		@(negedge clk);
	endtask

	task automatic settle();
		valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (RunCycles) @(negedge clk);
	endtask

	task automatic write_count(bit [6:0] value);
		settle();
		cfg_we <= 1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 0;
		sb.vcount = 32'(value);
		@(negedge clk);
	endtask

	// one graph: random arcs, some noise, the last word starts the run
	task automatic send_graph(int unsigned arcs);
		int unsigned n;
		bit [5:0] f, t;
		bit present;
		n = sb.live();
		for (int unsigned i = 0; i <= arcs; i++) begin
			if (n == 0 || $urandom_range(99) < 5) begin
				f = 6'($urandom_range(63));
				t = 6'($urandom_range(63));
			end else begin
				f = 6'($urandom_range(n - 1));
				t = 6'($urandom_range(n - 1));
			end
			present = ($urandom_range(99) >= 8);
			send_word(f, t, present, i == arcs);
		end
	endtask

	initial begin
		int unsigned sent;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// extremes, self-loop, duplicate, word with no arc
		send_word(0, 63, 1, 0);
		send_word(63, 0, 1, 0);
		send_word(5, 5, 1, 0);
		send_word(0, 63, 1, 0);
		send_word(7, 9, 0, 0);
		send_word(63, 63, 1, 1);
		// small graph with an out-of-range end
		write_count(3);
		send_word(2, 1, 1, 0);
		send_word(1, 2, 1, 0);
		send_word(3, 0, 1, 1);
		// count lowered after loading
		write_count(64);
		send_word(10, 11, 1, 0);
		send_word(1, 0, 1, 0);
		write_count(2);
		send_word(0, 1, 1, 1);
		// no vertices: everything dropped, run gives nothing
		write_count(0);
		send_word(0, 0, 1, 0);
		send_word(0, 0, 0, 1);
		// count above the vertex limit
		write_count(127);
		send_word(1, 2, 1, 0);
		send_word(0, 0, 0, 1);
		// single vertex
		write_count(1);
		send_word(0, 0, 1, 1);

		for (int p = 0; p < 4; p++) begin
			mode = idle_mode_t'(p);
			case (p)
				0: write_count(64);
				1: write_count(4);
				2: write_count(127);
				default: write_count(7'($urandom_range(2, 20)));
			endcase
			sent = 0;
			if (p == 1) begin
				// sends more words than the arc store can hold
				send_graph(MaxEdges + 6);
				sent += MaxEdges + 7;
			end
			if (p == 0) begin
				hold_req = 1;
				send_graph(3);
				send_graph(5);
				sent += 10;
			end
			while (sent < 60) begin
				int unsigned k;
				k = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
				send_graph(k);
				sent += k + 1;
			end
		end

		valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
